// ----- hw/rtl/tfr_pkg.sv -----
package tfr_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int ADDR_W      = 5;
  localparam int HOLD_BYTES  = 19;
  localparam int HOLD_W      = 8 * HOLD_BYTES;

  localparam logic [ADDR_W-1:0] FRAME_END = ADDR_W'(FRAME_BYTES);
  localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(FRAME_BYTES - 1);
  localparam logic [ADDR_W-1:0] POS_VER   = 5'd2;
  localparam logic [ADDR_W-1:0] POS_LEN   = 5'd3;
  localparam logic [ADDR_W-1:0] POS_SEQ   = 5'd4;
  localparam logic [ADDR_W-1:0] POS_HEND  = 5'd22;

  localparam logic [7:0] PAYLOAD_LEN      = 8'd19;
  localparam logic [7:0] SYNC_FIRST_RST   = 8'hA5;
  localparam logic [7:0] SYNC_SECOND_RST  = 8'h5A;
  localparam logic [7:0] VERSION_RST      = 8'h03;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CKSUM = 2'd1,
    ST_HDR   = 2'd2,
    ST_LINE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_VERSION     = 2'd2
  } cfg_idx_t;

endpackage

// ----- hw/rtl/telemetry_frame_receiver.sv -----
// Telemetry frame receiver.
// in_*  : one word per received UART byte (in_tuser = 0) or line error
//         event (in_tuser = 1). in_tready is high only while idle.
// out_* : one word per completed 24-byte frame or line error. Status in
//         out_tuser; decoded fields in out_tdata, zero unless accepted.
// cfg_* : sync_first (0), sync_second (1), expected_version (2); always ready.
// Bytes inside a frame are written to the frame RAM as they are taken. The byte
// that completes a frame starts a pass over the frame RAM through its single
// read port: read and sum all bytes (S_SCAN), check them (S_CHECK), on a resync
// move the tail down (S_COPY), then post the result (S_EMIT). A line error goes
// straight to S_EMIT to post its result.
// The output word sits in a register; new bytes are taken while it waits,
// but the next result is held back until out_tready frees the register.
// Reset (rst_n low, synchronous) empties the frame, drops a pending output
// and restores the register defaults; RAM contents are not cleared.
module telemetry_frame_receiver (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // rx_byte
  input  logic [0:0]    in_tuser,   // req_type
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [159:0]  out_tdata,  // resynced, seq, fault_word, c_fault, c_protocol,
                                    // c_readings, a_fault, a_protocol, a_readings, zero pad
  output logic [1:0]    out_tuser,  // status
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_COPY,
    S_EMIT
  } state_t;

  localparam int AW = tfr_pkg::ADDR_W;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            fill_r, fill_nxt;
  logic [AW-1:0]            cnt_r, cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic [AW-1:0]            pidx_r, pidx_nxt;
  logic [7:0]               sum_r, sum_nxt;
  logic [7:0]               prev_r, prev_nxt;
  logic                     ver_ok_r, ver_ok_nxt;
  logic                     len_ok_r, len_ok_nxt;
  logic                     found_r, found_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [tfr_pkg::HOLD_W-1:0] hold_r, hold_nxt;
  tfr_pkg::status_t         status_r, status_nxt;
  logic                     resync_r, resync_nxt;
  logic                     good_r, good_nxt;
  logic                     out_valid_r, out_valid_nxt;
  tfr_pkg::status_t         out_status_r, out_status_nxt;
  logic                     out_resync_r, out_resync_nxt;
  logic [tfr_pkg::HOLD_W-1:0] out_hold_r, out_hold_nxt;
  logic [7:0]               sync_first_r, sync_second_r, version_r;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [7:0]               ram_wdata, ram_rdata;
  logic                     in_acc, slot_free, sum_bad;

  tfr_frame_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign sum_bad   = (sum_r != 8'd0);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = 1'b0;
    pidx_nxt       = cnt_r;
    sum_nxt        = sum_r;
    prev_nxt       = prev_r;
    ver_ok_nxt     = ver_ok_r;
    len_ok_nxt     = len_ok_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    hold_nxt       = hold_r;
    status_nxt     = status_r;
    resync_nxt     = resync_r;
    good_nxt       = good_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_resync_nxt = out_resync_r;
    out_hold_nxt   = out_hold_r;
    ram_we         = 1'b0;
    ram_waddr      = fill_r;
    ram_wdata      = in_tdata;
    ram_raddr      = cnt_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0]) begin
            fill_nxt   = '0;
            status_nxt = tfr_pkg::ST_LINE;
            resync_nxt = 1'b0;
            good_nxt   = 1'b0;
            state_nxt  = S_EMIT;
          end else begin
            case (fill_r)
              5'd0: begin
                if (in_tdata == sync_first_r) begin
                  ram_we   = 1'b1;
                  fill_nxt = 5'd1;
                end
              end
              5'd1: begin
                ram_we = 1'b1;
                if (in_tdata == sync_second_r) begin
                  fill_nxt = 5'd2;
                end else begin
                  ram_waddr = '0;
                  fill_nxt  = (in_tdata == sync_first_r) ? 5'd1 : 5'd0;
                end
              end
              default: begin
                ram_we = 1'b1;
                if (fill_r == tfr_pkg::LAST_IDX) begin
                  fill_nxt  = '0;
                  cnt_nxt   = '0;
                  sum_nxt   = '0;
                  found_nxt = 1'b0;
                  state_nxt = S_SCAN;
                end else begin
                  fill_nxt = fill_r + 5'd1;
                end
              end
            endcase
          end
        end
      end

      S_SCAN: begin
        if (cnt_r != tfr_pkg::FRAME_END) begin
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + 5'd1;
        end
        if (pend_r) begin
          sum_nxt  = sum_r + ram_rdata;
          prev_nxt = ram_rdata;
          if (pidx_r == tfr_pkg::POS_VER) begin
            ver_ok_nxt = (ram_rdata == version_r);
          end
          if (pidx_r == tfr_pkg::POS_LEN) begin
            len_ok_nxt = (ram_rdata == tfr_pkg::PAYLOAD_LEN);
          end
          if (pidx_r >= tfr_pkg::POS_SEQ && pidx_r <= tfr_pkg::POS_HEND) begin
            hold_nxt = {ram_rdata, hold_r[tfr_pkg::HOLD_W-1:8]};
          end
          if (pidx_r >= tfr_pkg::POS_VER && !found_r &&
              prev_r == sync_first_r && ram_rdata == sync_second_r) begin
            found_nxt = 1'b1;
            pos_nxt   = pidx_r - 5'd1;
          end
          if (pidx_r == tfr_pkg::LAST_IDX) begin
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        good_nxt   = !sum_bad && ver_ok_r && len_ok_r;
        status_nxt = sum_bad ? tfr_pkg::ST_CKSUM :
                     ((ver_ok_r && len_ok_r) ? tfr_pkg::ST_OK : tfr_pkg::ST_HDR);
        if (!sum_bad && ver_ok_r && len_ok_r) begin
          resync_nxt = 1'b0;
          fill_nxt   = '0;
          state_nxt  = S_EMIT;
        end else if (found_r) begin
          resync_nxt = 1'b1;
          fill_nxt   = tfr_pkg::FRAME_END - pos_r;
          cnt_nxt    = pos_r;
          state_nxt  = S_COPY;
        end else begin
          resync_nxt = 1'b0;
          fill_nxt   = '0;
          state_nxt  = S_EMIT;
        end
      end

      S_COPY: begin
        if (cnt_r != tfr_pkg::FRAME_END) begin
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + 5'd1;
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_r - pos_r;
          ram_wdata = ram_rdata;
          if (pidx_r == tfr_pkg::LAST_IDX) begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_resync_nxt = resync_r;
          out_hold_nxt   = good_r ? hold_r : '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fill_r        <= '0;
      cnt_r         <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      sync_first_r  <= tfr_pkg::SYNC_FIRST_RST;
      sync_second_r <= tfr_pkg::SYNC_SECOND_RST;
      version_r     <= tfr_pkg::VERSION_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          tfr_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
          tfr_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_data;
          tfr_pkg::CFG_VERSION:     version_r     <= cfg_data;
          default: ;
        endcase
      end
    end
    pidx_r       <= pidx_nxt;
    sum_r        <= sum_nxt;
    prev_r       <= prev_nxt;
    ver_ok_r     <= ver_ok_nxt;
    len_ok_r     <= len_ok_nxt;
    found_r      <= found_nxt;
    pos_r        <= pos_nxt;
    hold_r       <= hold_nxt;
    status_r     <= status_nxt;
    resync_r     <= resync_nxt;
    good_r       <= good_nxt;
    out_status_r <= out_status_nxt;
    out_resync_r <= out_resync_nxt;
    out_hold_r   <= out_hold_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_hold_r, out_resync_r};

endmodule

// ----- hw/rtl/tfr_frame_ram.sv -----
module tfr_frame_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tfr_pkg::ADDR_W-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [tfr_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                 rdata
);

  logic [7:0] mem [0:tfr_pkg::FRAME_BYTES-1];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- tb/sv/telemetry_frame_receiver_tb.sv -----
`timescale 1ns / 100ps

module telemetry_frame_receiver_tb;

  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int PHASE_WORDS    = 105;

  localparam logic [1:0] FILL_RANDOM = 2'd0;
  localparam logic [1:0] FILL_ZERO   = 2'd1;
  localparam logic [1:0] FILL_ONES   = 2'd2;

  typedef enum logic [3:0] {
    FR_GOOD, FR_BAD_SUM, FR_BAD_VER, FR_BAD_LEN, FR_RESYNC, FR_TAIL_SYNC, FR_CUT, FR_RETRY
  } frame_kind_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [47:0] a_readings;
    logic [7:0]  a_protocol;
    logic [7:0]  a_fault;
    logic [47:0] c_readings;
    logic [7:0]  c_protocol;
    logic [7:0]  c_fault;
    logic [15:0] fault_word;
    logic [7:0]  seq;
    logic        resynced;
  } frame_fields_t;

  typedef struct packed {
    tfr_pkg::status_t status;
    frame_fields_t    fields;
  } frame_result_t;

  typedef struct packed {
    logic             is_frame;
    frame_kind_t      kind;
    logic [1:0]       fill;
    logic             line_err;
    logic [7:0]       data;
    logic             typed;
    tfr_pkg::status_t status;
    logic             resynced;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [159:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [7:0]   cfg_data;

  logic [7:0]    reg_sync1   = tfr_pkg::SYNC_FIRST_RST;
  logic [7:0]    reg_sync2   = tfr_pkg::SYNC_SECOND_RST;
  logic [7:0]    reg_version = tfr_pkg::VERSION_RST;
  logic [7:0]    rx_frame [tfr_pkg::FRAME_BYTES];
  int            rx_fill = 0;

  frame_result_t pending_results [$];
  frame_result_t drv_want = '0;
  bit            drv_typed = 1'b0;
  bit            idle_on = 1'b1;
  bit            hold_req = 1'b0;
  int            words_sent = 0;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;

  // line errors, hunt restart, sync retry, frame extremes, rejects, resync, tail sync byte, cut frame
  dir_row_t dir_table [0:20] = '{
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b1, 8'h00, 1'b1, tfr_pkg::ST_LINE, 1'b0},
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b0, 8'h00, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b0, 8'hFF, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b0, tfr_pkg::SYNC_FIRST_RST, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b0, 8'h00, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b0, tfr_pkg::SYNC_FIRST_RST, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b0, tfr_pkg::SYNC_FIRST_RST, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b0, tfr_pkg::SYNC_SECOND_RST, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b1, 8'hFF, 1'b1, tfr_pkg::ST_LINE, 1'b0},
    '{1'b1, FR_GOOD, FILL_ZERO, 1'b0, 8'h00, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b1, FR_GOOD, FILL_ONES, 1'b0, 8'h00, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b1, FR_BAD_SUM, FILL_ZERO, 1'b0, 8'h00, 1'b1, tfr_pkg::ST_CKSUM, 1'b0},
    '{1'b1, FR_BAD_VER, FILL_ZERO, 1'b0, 8'h00, 1'b1, tfr_pkg::ST_HDR, 1'b0},
    '{1'b1, FR_BAD_LEN, FILL_ZERO, 1'b0, 8'h00, 1'b1, tfr_pkg::ST_HDR, 1'b0},
    '{1'b1, FR_RESYNC, FILL_RANDOM, 1'b0, 8'h00, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b1, 8'h00, 1'b1, tfr_pkg::ST_LINE, 1'b0},
    '{1'b1, FR_TAIL_SYNC, FILL_ZERO, 1'b0, 8'h00, 1'b1, tfr_pkg::ST_CKSUM, 1'b0},
    '{1'b0, FR_GOOD, FILL_RANDOM, 1'b0, tfr_pkg::SYNC_SECOND_RST, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b1, FR_GOOD, FILL_RANDOM, 1'b0, 8'h00, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b1, FR_RETRY, FILL_RANDOM, 1'b0, 8'h00, 1'b0, tfr_pkg::ST_OK, 1'b0},
    '{1'b1, FR_CUT, FILL_RANDOM, 1'b0, 8'h00, 1'b0, tfr_pkg::ST_OK, 1'b0}
  };

  telemetry_frame_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic bit deframe_word(input bit line_err, input logic [7:0] b,
                                      output frame_result_t r);
    logic [7:0] sum;
    int         start;
    r = '0;
    sum = '0;
    start = 0;
    if (line_err) begin
      rx_fill = 0;
      r.status = tfr_pkg::ST_LINE;
      return 1'b1;
    end
    if (rx_fill == 0) begin
      if (b == reg_sync1) begin
        rx_frame[0] = b;
        rx_fill = 1;
      end
      return 1'b0;
    end
    if (rx_fill == 1) begin
      if (b == reg_sync2) begin
        rx_frame[1] = b;
        rx_fill = 2;
      end else begin
        rx_frame[0] = b;
        rx_fill = (b == reg_sync1) ? 1 : 0;
      end
      return 1'b0;
    end
    rx_frame[rx_fill] = b;
    rx_fill++;
    if (rx_fill < tfr_pkg::FRAME_BYTES) return 1'b0;

    for (int k = 0; k < tfr_pkg::FRAME_BYTES; k++) sum += rx_frame[k];
    if (sum != 8'd0) begin
      r.status = tfr_pkg::ST_CKSUM;
    end else if (rx_frame[tfr_pkg::POS_VER] != reg_version ||
                 rx_frame[tfr_pkg::POS_LEN] != tfr_pkg::PAYLOAD_LEN) begin
      r.status = tfr_pkg::ST_HDR;
    end else begin
      r.status            = tfr_pkg::ST_OK;
      r.fields.seq        = rx_frame[4];
      r.fields.fault_word = {rx_frame[6], rx_frame[5]};
      r.fields.c_fault    = rx_frame[7];
      r.fields.c_protocol = rx_frame[8];
      r.fields.c_readings = {rx_frame[14], rx_frame[13], rx_frame[12],
                             rx_frame[11], rx_frame[10], rx_frame[9]};
      r.fields.a_fault    = rx_frame[15];
      r.fields.a_protocol = rx_frame[16];
      r.fields.a_readings = {rx_frame[22], rx_frame[21], rx_frame[20],
                             rx_frame[19], rx_frame[18], rx_frame[17]};
      rx_fill = 0;
      return 1'b1;
    end

    // rejected: look for the next sync pair and slide the tail down
    for (int i = 1; i < tfr_pkg::FRAME_BYTES - 1; i++) begin
      if (start == 0 && rx_frame[i] == reg_sync1 && rx_frame[i+1] == reg_sync2) start = i;
    end
    if (start != 0) begin
      for (int j = 0; j < tfr_pkg::FRAME_BYTES - start; j++) rx_frame[j] = rx_frame[start + j];
      rx_fill = tfr_pkg::FRAME_BYTES - start;
      r.fields.resynced = 1'b1;
    end else begin
      rx_fill = 0;
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [47:0] got, logic [47:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // scoreboard: config writes mirrored first, then results checked, then the accepted input word is predicted
  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    frame_result_t calc;
    bit            made;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tfr_pkg::CFG_SYNC_FIRST:  reg_sync1 = cfg_data;
          tfr_pkg::CFG_SYNC_SECOND: reg_sync2 = cfg_data;
          tfr_pkg::CFG_VERSION:     reg_version = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result word, status %0d", out_tuser));
        end else begin
          want = pending_results.pop_front();
          got.status = tfr_pkg::status_t'(out_tuser);
          got.fields = out_tdata;
          check_field("status", 48'(got.status), 48'(want.status));
          check_field("resynced", 48'(got.fields.resynced), 48'(want.fields.resynced));
          check_field("seq", 48'(got.fields.seq), 48'(want.fields.seq));
          check_field("fault_word", 48'(got.fields.fault_word), 48'(want.fields.fault_word));
          check_field("c_fault", 48'(got.fields.c_fault), 48'(want.fields.c_fault));
          check_field("c_protocol", 48'(got.fields.c_protocol), 48'(want.fields.c_protocol));
          check_field("c_readings", got.fields.c_readings, want.fields.c_readings);
          check_field("a_fault", 48'(got.fields.a_fault), 48'(want.fields.a_fault));
          check_field("a_protocol", 48'(got.fields.a_protocol), 48'(want.fields.a_protocol));
          check_field("a_readings", got.fields.a_readings, want.fields.a_readings);
        end
      end
      if (in_tvalid && in_tready) begin
        made = deframe_word(in_tuser[0], in_tdata, calc);
        if (drv_typed) pending_results.push_back(drv_want);
        else if (made) pending_results.push_back(calc);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_word(bit line_err, logic [7:0] b, bit typed = 1'b0,
                           frame_result_t want = '0);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = line_err;
    in_tdata  = b;
    drv_typed = typed;
    drv_want  = want;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic send_frame(frame_kind_t kind, logic [1:0] fill, bit typed = 1'b0,
                            frame_result_t want = '0);
    logic [7:0] fb [tfr_pkg::FRAME_BYTES];
    logic [7:0] sum;
    int         pos;
    int         cut;
    sum = '0;
    fb[0] = reg_sync1;
    fb[1] = reg_sync2;
    fb[2] = reg_version;
    fb[3] = tfr_pkg::PAYLOAD_LEN;
    for (int k = 4; k < tfr_pkg::FRAME_BYTES - 1; k++) begin
      case (fill)
        FILL_ZERO: fb[k] = 8'h00;
        FILL_ONES: fb[k] = 8'hFF;
        default:   fb[k] = 8'($urandom_range(0, 255));
      endcase
    end
    case (kind)
      FR_BAD_VER: fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
      FR_BAD_LEN: fb[3] = fb[3] ^ 8'($urandom_range(1, 255));
      FR_RESYNC: begin
        pos = $urandom_range(1, 21);
        fb[pos]   = reg_sync1;
        fb[pos+1] = reg_sync2;
      end
      default: ;
    endcase
    for (int k = 0; k < tfr_pkg::FRAME_BYTES - 1; k++) sum += fb[k];
    fb[tfr_pkg::FRAME_BYTES-1] = -sum;
    if (kind == FR_BAD_SUM || kind == FR_RESYNC)
      fb[tfr_pkg::FRAME_BYTES-1] = fb[tfr_pkg::FRAME_BYTES-1] + 8'($urandom_range(1, 255));
    if (kind == FR_TAIL_SYNC) fb[tfr_pkg::FRAME_BYTES-1] = reg_sync1;
    if (kind == FR_RETRY) send_word(1'b0, reg_sync1);
    cut = (kind == FR_CUT) ? $urandom_range(1, tfr_pkg::FRAME_BYTES - 1) : tfr_pkg::FRAME_BYTES;
    for (int k = 0; k < cut; k++)
      send_word(1'b0, fb[k], typed && k == tfr_pkg::FRAME_BYTES - 1, want);
    if (kind == FR_CUT) send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain_outputs();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(tfr_pkg::cfg_idx_t idx, logic [7:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(logic [7:0] s1, logic [7:0] s2, logic [7:0] ver);
    cfg_write(tfr_pkg::CFG_SYNC_FIRST, s1);
    cfg_write(tfr_pkg::CFG_SYNC_SECOND, s2);
    cfg_write(tfr_pkg::CFG_VERSION, ver);
  endtask

  task automatic random_action();
    int         pick;
    logic [1:0] fill;
    pick = $urandom_range(0, 99);
    fill = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 2)) : FILL_RANDOM;
    if (pick < 30)      send_frame(FR_GOOD, fill);
    else if (pick < 38) send_frame(FR_BAD_SUM, fill);
    else if (pick < 44) send_frame(FR_BAD_VER, fill);
    else if (pick < 50) send_frame(FR_BAD_LEN, fill);
    else if (pick < 58) send_frame(FR_RESYNC, fill);
    else if (pick < 62) send_frame(FR_TAIL_SYNC, fill);
    else if (pick < 66) send_frame(FR_CUT, fill);
    else if (pick < 70) send_frame(FR_RETRY, fill);
    else if (pick < 80) repeat ($urandom_range(1, 6)) send_word(1'b0, 8'($urandom_range(0, 255)));
    else if (pick < 90) send_word(1'b0, $urandom_range(0, 1) ? reg_sync1 : reg_sync2);
    else if (pick < 97) send_word(1'b1, 8'($urandom_range(0, 255)));
    else                drain_outputs();
  endtask

  initial begin
    frame_result_t want;
    int            goal;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = '0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[r]) begin
      want = '0;
      want.status = dir_table[r].status;
      want.fields.resynced = dir_table[r].resynced;
      if (dir_table[r].is_frame)
        send_frame(dir_table[r].kind, dir_table[r].fill, dir_table[r].typed, want);
      else
        send_word(dir_table[r].line_err, dir_table[r].data, dir_table[r].typed, want);
    end

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain_outputs();
        case (ph)
          1: set_config(8'h00, 8'hFF, 8'hFF);
          2: set_config(8'hFF, 8'h00, 8'h00);
          3: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
          default: set_config(tfr_pkg::SYNC_FIRST_RST, tfr_pkg::SYNC_SECOND_RST,
                              tfr_pkg::VERSION_RST);
        endcase
      end
      if (ph == 2) begin
        // long result-side hold-off while frames keep coming
        hold_req = 1'b1;
        repeat (4) send_frame(FR_GOOD, FILL_RANDOM);
        drain_outputs();
      end
      idle_on = (ph < 4);
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) random_action();
    end

    drain_outputs();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_frame_ram.sv
hw/rtl/telemetry_frame_receiver.sv
tb/sv/telemetry_frame_receiver_tb.sv
